@@ rtl/core/pisr_pkg.sv @@
// shared types, codes and reset values for the pi speed regulator motor mix
// no dependencies; used by pisr_mix and pi_speed_regulator_motor_mix
package pisr_pkg;

    // field widths
    localparam int unsigned LEVEL_W  = 22;
    localparam int unsigned PGAIN_W  = 8;
    localparam int unsigned IGAIN_W  = 16;
    localparam int unsigned ILIM_W   = 20;
    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned UOFF_W   = 15;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned INTEG_W  = 21;
    localparam int unsigned ERR_W    = 23;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 22;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_OFFSET    = 3'd6;

    // reset values
    localparam logic [LEVEL_W-1:0] RST_GOAL_LEVEL     = 22'd1000000;
    localparam logic [PGAIN_W-1:0] RST_PROP_GAIN      = 8'd4;
    localparam logic [IGAIN_W-1:0] RST_INTEGRAL_GAIN  = 16'd3277;
    localparam logic [LEVEL_W-1:0] RST_DEADBAND       = 22'd50000;
    localparam logic [ILIM_W-1:0]  RST_INTEGRAL_LIMIT = 20'd44000;
    localparam logic [UOFF_W-1:0]  RST_SLOW_SPEED     = 15'd600;
    localparam logic [UOFF_W-1:0]  RST_TURN_OFFSET    = 15'd300;

    // direction codes
    localparam logic [CODE_W-1:0] DRIVE_LEFT     = 3'd0;
    localparam logic [CODE_W-1:0] DRIVE_RIGHT    = 3'd1;
    localparam logic [CODE_W-1:0] DRIVE_FORWARD  = 3'd2;
    localparam logic [CODE_W-1:0] DRIVE_BACKWARD = 3'd3;
    localparam logic [CODE_W-1:0] DRIVE_STOP     = 3'd4;

    // steering phase codes
    localparam logic [CODE_W-1:0] PHASE_LEFT    = 3'd0;
    localparam logic [CODE_W-1:0] PHASE_RIGHT   = 3'd1;
    localparam logic [CODE_W-1:0] PHASE_FORWARD = 3'd2;

    typedef struct packed {
        logic signed [SPEED_W-1:0] right;
        logic signed [SPEED_W-1:0] left;
    } t_speed_pair;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [CODE_W-1:0]         dir;
        logic [CODE_W-1:0]         phase;
        logic [UOFF_W-1:0]         offset;
        t_speed_pair               last;
    } t_mix_req;

endpackage

@@ rtl/core/pisr_mix.sv @@
// direction mapping of one speed onto right and left motor commands
// depends on pisr_pkg
module pisr_mix (
    input  pisr_pkg::t_mix_req    i_req,
    output pisr_pkg::t_speed_pair o_cmd
);

    localparam int unsigned WW = pisr_pkg::SPEED_W + 1;

    function automatic logic signed [pisr_pkg::SPEED_W-1:0] sat16(
        input logic signed [WW-1:0] v
    );
        logic signed [WW-1:0] hi;
        logic signed [WW-1:0] lo;
        hi = WW'(signed'({1'b0, {(pisr_pkg::SPEED_W-1){1'b1}}}));
        lo = -hi - WW'(1);
        if (v > hi) begin
            sat16 = hi[pisr_pkg::SPEED_W-1:0];
        end else if (v < lo) begin
            sat16 = lo[pisr_pkg::SPEED_W-1:0];
        end else begin
            sat16 = v[pisr_pkg::SPEED_W-1:0];
        end
    endfunction

    logic signed [WW-1:0]                s_ext;
    logic signed [WW-1:0]                off_ext;
    logic signed [pisr_pkg::SPEED_W-1:0] s_pos;
    logic signed [pisr_pkg::SPEED_W-1:0] s_neg;
    logic signed [pisr_pkg::SPEED_W-1:0] s_plus;
    logic signed [pisr_pkg::SPEED_W-1:0] s_minus;

    assign s_ext   = WW'(i_req.speed);
    assign off_ext = signed'({2'b00, i_req.offset});
    assign s_pos   = i_req.speed;
    assign s_neg   = sat16(-s_ext);
    assign s_plus  = sat16(s_ext + off_ext);
    assign s_minus = sat16(s_ext - off_ext);

    always_comb begin
        o_cmd = i_req.last;
        unique case (i_req.dir)
            pisr_pkg::DRIVE_LEFT: begin
                o_cmd.right = s_pos;
                o_cmd.left  = s_neg;
            end
            pisr_pkg::DRIVE_RIGHT: begin
                o_cmd.right = s_neg;
                o_cmd.left  = s_pos;
            end
            pisr_pkg::DRIVE_FORWARD: begin
                priority if (i_req.phase == pisr_pkg::PHASE_FORWARD) begin
                    o_cmd.right = s_pos;
                    o_cmd.left  = s_pos;
                end else if (i_req.phase == pisr_pkg::PHASE_LEFT) begin
                    o_cmd.right = s_plus;
                    o_cmd.left  = s_minus;
                end else if (i_req.phase == pisr_pkg::PHASE_RIGHT) begin
                    o_cmd.right = s_minus;
                    o_cmd.left  = s_plus;
                end else begin
                    o_cmd = i_req.last;
                end
            end
            pisr_pkg::DRIVE_BACKWARD: begin
                o_cmd.right = s_neg;
                o_cmd.left  = s_neg;
            end
            pisr_pkg::DRIVE_STOP: begin
                o_cmd.right = '0;
                o_cmd.left  = '0;
            end
            default: begin
                o_cmd = i_req.last;
            end
        endcase
    end

endmodule

@@ rtl/core/pi_speed_regulator_motor_mix.sv @@
// top level of the pi speed regulator with motor mix: five-stage pipeline
// depends on pisr_pkg and pisr_mix

// The block takes one request per clock cycle while the output side does not
// stall and returns one pair of motor commands per request, in order; each
// request passes through the five pipeline registers in order before its
// result is presented on the result channel. Stage one holds the request;
// stage two forms the error, applies the deadband and updates the clamped
// integrator, which is the only feedback loop on the regulator side; stage
// three holds the proportional and integral products; stage four sums them,
// truncates toward zero and saturates to 16 bits; the output register applies
// the direction and steering mapping and also serves as the memory of the last
// commands issued. Each stage moves whenever the next one is empty or moving,
// so bubbles close up and a stalled output only stops the pipeline once it is
// full. Configuration writes are always accepted and take effect at once;
// write them only while no request is in flight. Writes to an index beyond the
// register list are dropped.
module pi_speed_regulator_motor_mix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [21:0] intensity, [22] reg_enable, [25:23] direction, [28:26] phase_dir,
    // [31:29] zero
    input  logic [31:0] s_axis_tdata,
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] right_speed, [31:16] left_speed
    output logic [31:0] m_axis_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pisr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pisr_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned LW   = pisr_pkg::LEVEL_W;
    localparam int unsigned EW   = pisr_pkg::ERR_W;
    localparam int unsigned IW   = pisr_pkg::INTEG_W;
    localparam int unsigned SW   = pisr_pkg::SPEED_W;
    localparam int unsigned CW   = pisr_pkg::CODE_W;
    localparam int unsigned AW   = EW + 2;          // integrator sum before clamp
    localparam int unsigned PEW  = pisr_pkg::PGAIN_W + 1 + EW;
    localparam int unsigned IAW  = pisr_pkg::IGAIN_W + 1 + IW;
    localparam int unsigned TW   = PEW + 16;        // full q16 total
    localparam int unsigned QW   = TW - 16;

    // configuration registers
    logic [LW-1:0]                    r_goal_level;
    logic [pisr_pkg::PGAIN_W-1:0]     r_prop_gain;
    logic [pisr_pkg::IGAIN_W-1:0]     r_integral_gain;
    logic [LW-1:0]                    r_deadband;
    logic [pisr_pkg::ILIM_W-1:0]      r_integral_limit;
    logic [pisr_pkg::UOFF_W-1:0]      r_slow_speed;
    logic [pisr_pkg::UOFF_W-1:0]      r_turn_offset;

    // integrator state
    logic signed [IW-1:0]             r_integral;

    // stage valids
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic go0, go1, go2, go3, go4;

    // stage 0: request register
    logic [LW-1:0] r_intensity0;
    logic          r_enable0;
    logic [CW-1:0] r_dir0;
    logic [CW-1:0] r_phase0;

    // stage 1: error and clamped integral
    logic signed [EW-1:0] r_err1;
    logic signed [IW-1:0] r_acc1;
    logic                 r_enable1;
    logic                 r_dead1;
    logic [CW-1:0]        r_dir1;
    logic [CW-1:0]        r_phase1;

    // stage 2: products
    logic signed [PEW-1:0] r_pe2;
    logic signed [IAW-1:0] r_ia2;
    logic                  r_enable2;
    logic                  r_dead2;
    logic [CW-1:0]         r_dir2;
    logic [CW-1:0]         r_phase2;

    // stage 3: speed
    logic signed [SW-1:0] r_speed3;
    logic [CW-1:0]        r_dir3;
    logic [CW-1:0]        r_phase3;

    // stage 4: result register, doubles as last commands
    pisr_pkg::t_speed_pair r_cmd;

    // handshake and stage advance
    assign go4 = !r_v4 || m_axis_tready;
    assign go3 = !r_v3 || go4;
    assign go2 = !r_v2 || go3;
    assign go1 = !r_v1 || go2;
    assign go0 = !r_v0 || go1;

    assign s_axis_tready = go0;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {r_cmd.left, r_cmd.right};
    assign o_cfg_ready   = 1'b1;

    // stage 1 logic: error, deadband, integrator with clamp
    logic signed [EW-1:0] n_err;
    logic [EW-1:0]        err_mag;
    logic                 n_dead;
    logic signed [AW-1:0] acc_raw;
    logic signed [AW-1:0] lim_pos;
    logic signed [AW-1:0] lim_neg;
    logic signed [IW-1:0] n_acc;

    assign n_err   = signed'({1'b0, r_goal_level}) - signed'({1'b0, r_intensity0});
    assign err_mag = n_err[EW-1] ? EW'(-n_err) : EW'(n_err);
    assign n_dead  = err_mag < {1'b0, r_deadband};
    assign acc_raw = AW'(r_integral) + AW'(n_err);
    assign lim_pos = signed'(AW'(r_integral_limit));
    assign lim_neg = -lim_pos;

    always_comb begin
        priority if (acc_raw > lim_pos) begin
            n_acc = lim_pos[IW-1:0];
        end else if (acc_raw < lim_neg) begin
            n_acc = lim_neg[IW-1:0];
        end else begin
            n_acc = acc_raw[IW-1:0];
        end
    end

    // stage 3 logic: q16 sum, truncation toward zero, saturation
    logic signed [TW-1:0] total;
    logic signed [QW-1:0] quot_floor;
    logic signed [QW-1:0] quot;
    logic signed [SW-1:0] pi_speed;
    logic signed [SW-1:0] n_speed;

    assign total      = signed'({r_pe2, 16'h0000}) + TW'(r_ia2);
    assign quot_floor = total[TW-1:16];
    assign quot       = (total[TW-1] && (total[15:0] != 16'h0000))
                        ? quot_floor + QW'(1) : quot_floor;

    always_comb begin
        priority if (quot > QW'(signed'({1'b0, {(SW-1){1'b1}}}))) begin
            pi_speed = {1'b0, {(SW-1){1'b1}}};
        end else if (quot < QW'(signed'({1'b1, {(SW-1){1'b0}}}))) begin
            pi_speed = {1'b1, {(SW-1){1'b0}}};
        end else begin
            pi_speed = quot[SW-1:0];
        end
    end

    // disabled regulator runs at the slow speed, deadband gives standstill
    always_comb begin
        priority if (!r_enable2) begin
            n_speed = signed'({1'b0, r_slow_speed});
        end else if (r_dead2) begin
            n_speed = '0;
        end else begin
            n_speed = pi_speed;
        end
    end

    // stage 4 logic: direction mapping
    pisr_pkg::t_mix_req    mix_req;
    pisr_pkg::t_speed_pair n_cmd;

    assign mix_req.speed  = r_speed3;
    assign mix_req.dir    = r_dir3;
    assign mix_req.phase  = r_phase3;
    assign mix_req.offset = r_turn_offset;
    assign mix_req.last   = r_cmd;

    pisr_mix u_mix (
        .i_req (mix_req),
        .o_cmd (n_cmd)
    );

    // control state, configuration and integrator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0             <= 1'b0;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_v3             <= 1'b0;
            r_v4             <= 1'b0;
            r_integral       <= '0;
            r_cmd            <= '0;
            r_goal_level     <= pisr_pkg::RST_GOAL_LEVEL;
            r_prop_gain      <= pisr_pkg::RST_PROP_GAIN;
            r_integral_gain  <= pisr_pkg::RST_INTEGRAL_GAIN;
            r_deadband       <= pisr_pkg::RST_DEADBAND;
            r_integral_limit <= pisr_pkg::RST_INTEGRAL_LIMIT;
            r_slow_speed     <= pisr_pkg::RST_SLOW_SPEED;
            r_turn_offset    <= pisr_pkg::RST_TURN_OFFSET;
        end else begin
            if (go0) r_v0 <= s_axis_tvalid;
            if (go1) r_v1 <= r_v0;
            if (go2) r_v2 <= r_v1;
            if (go3) r_v3 <= r_v2;
            if (go4) r_v4 <= r_v3;

            // integrator moves once per enabled request that leaves the deadband
            if (go1 && r_v0 && r_enable0 && !n_dead) begin
                r_integral <= n_acc;
            end

            if (go4 && r_v3) begin
                r_cmd <= n_cmd;
            end

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pisr_pkg::CFG_GOAL_LEVEL:
                        r_goal_level <= i_cfg_data[LW-1:0];
                    pisr_pkg::CFG_PROP_GAIN:
                        r_prop_gain <= i_cfg_data[pisr_pkg::PGAIN_W-1:0];
                    pisr_pkg::CFG_INTEGRAL_GAIN:
                        r_integral_gain <= i_cfg_data[pisr_pkg::IGAIN_W-1:0];
                    pisr_pkg::CFG_DEADBAND:
                        r_deadband <= i_cfg_data[LW-1:0];
                    pisr_pkg::CFG_INTEGRAL_LIMIT:
                        r_integral_limit <= i_cfg_data[pisr_pkg::ILIM_W-1:0];
                    pisr_pkg::CFG_SLOW_SPEED:
                        r_slow_speed <= i_cfg_data[pisr_pkg::UOFF_W-1:0];
                    pisr_pkg::CFG_TURN_OFFSET:
                        r_turn_offset <= i_cfg_data[pisr_pkg::UOFF_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (go0 && s_axis_tvalid) begin
            r_intensity0 <= s_axis_tdata[LW-1:0];
            r_enable0    <= s_axis_tdata[LW];
            r_dir0       <= s_axis_tdata[LW+CW:LW+1];
            r_phase0     <= s_axis_tdata[LW+2*CW:LW+CW+1];
        end
        if (go1 && r_v0) begin
            r_err1    <= n_err;
            r_acc1    <= n_acc;
            r_enable1 <= r_enable0;
            r_dead1   <= n_dead;
            r_dir1    <= r_dir0;
            r_phase1  <= r_phase0;
        end
        if (go2 && r_v1) begin
            r_pe2     <= signed'({1'b0, r_prop_gain}) * r_err1;
            r_ia2     <= signed'({1'b0, r_integral_gain}) * r_acc1;
            r_enable2 <= r_enable1;
            r_dead2   <= r_dead1;
            r_dir2    <= r_dir1;
            r_phase2  <= r_phase1;
        end
        if (go3 && r_v2) begin
            r_speed3 <= n_speed;
            r_dir3   <= r_dir2;
            r_phase3 <= r_phase2;
        end
    end

endmodule
